// ----- rtl/region_map_frame_allocator_unit_assert.svh -----
// assertion macros for the region map frame allocator
`ifndef REGION_MAP_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define REGION_MAP_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define RMFA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rmfa assertion failed");
`define RMFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rmfa assertion failed");
`else
`define RMFA_ASSERT(lbl, prop)
`define RMFA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/rmfa_pkg.sv -----
package rmfa_pkg;

  localparam int unsigned AddrW = 64;

  localparam logic [1:0] CmdAdd   = 2'd0;
  localparam logic [1:0] CmdQuery = 2'd1;
  localparam logic [1:0] CmdAlloc = 2'd2;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusOom  = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  localparam logic [31:0] TypeMultibootFree = 32'd1;
  localparam logic [31:0] TypeUefiFree      = 32'd7;

  localparam logic [AddrW-1:0] LowMemLimit = 64'h0000_0000_0010_0000;
  localparam logic [AddrW-1:0] PageMask    = 64'h0000_0000_0000_0FFF;
  localparam logic [AddrW-1:0] PageBytes   = 64'h0000_0000_0000_1000;

  localparam logic RegReserveStart = 1'b0;
  localparam logic RegReserveEnd   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QUERY,
    S_SEEK,
    S_ALIGN,
    S_STEP,
    S_DONE
  } rmfa_state_e;

  typedef struct packed {
    logic shift;
    logic load;
  } rmfa_cell_ctl_t;

endpackage

// ----- rtl/region_map_frame_allocator_unit.sv -----
// Region map frame allocator. Free regions live in a ring of REGION_SLOTS cells
// that rotates by one cell per cycle while a query or seek shifts it; only the
// region at the ring head is examined. Every command is settled into a staging
// register and handed to the output register from a done cycle, so a stalled
// result holds the input side until the done state can hand it on: a new beat
// is taken as soon as the block is back in idle. Add and unused commands pass
// only through the accepting cycle and the done cycle. A query rotates the ring
// once around between the accepting cycle and the done cycle. An allocate
// rotates until the cursor's region reaches the head and a cycle sees the match,
// then aligns and steps through the region; hopping to the next region goes back
// to rotating and matching. One command is in work at a time; the done cycle
// waits for the output register to be free. No clearing pass after reset.
module region_map_frame_allocator_unit
  import rmfa_pkg::*;
#(
  parameter int unsigned REGION_SLOTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic              entry_format_i,
  input  logic [31:0]       entry_type_i,
  input  logic [AddrW-1:0]  entry_base_i,
  input  logic [AddrW-1:0]  entry_size_i,
  input  logic [AddrW-1:0]  query_addr_i,
  input  logic [AddrW-1:0]  query_length_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [AddrW-1:0]  frame_addr_o,
  output logic              range_safe_o,
  output logic [6:0]        regions_held_o,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [AddrW-1:0]  pwdata,
  output logic [AddrW-1:0]  prdata,
  output logic              pready
);

  localparam int unsigned IdxW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(REGION_SLOTS + 1);

  `include "region_map_frame_allocator_unit_assert.svh"

  // registers
  logic [AddrW-1:0] rsv_start_q, rsv_end_q;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[3] == RegReserveEnd) ? rsv_end_q : rsv_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsv_start_q <= '0;
      rsv_end_q   <= '0;
    end else if (cfg_we) begin
      if (paddr[3] == RegReserveStart) rsv_start_q <= pwdata;
      else rsv_end_q <= pwdata;
    end
  end

  // control state
  rmfa_state_e      state_q, state_d;
  logic [CntW-1:0]  total_q, total_d;
  logic [CntW-1:0]  cursor_q, cursor_d;
  logic [AddrW-1:0] offset_q, offset_d;
  logic [IdxW-1:0]  pos_q, pos_d;        // region index sitting at the ring head
  logic [CntW-1:0]  qcnt_q, qcnt_d;
  logic [AddrW-1:0] qaddr_q, qaddr_d, qlen_q, qlen_d;
  logic [AddrW-1:0] aligned_q, aligned_d, end_q, end_d;
  logic [1:0]       res_status_q, res_status_d;
  logic [AddrW-1:0] res_frame_q, res_frame_d;
  logic             res_safe_q, res_safe_d;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       status_q, status_d;
  logic [AddrW-1:0] frame_q, frame_d;
  logic             safe_q, safe_d;
  logic [6:0]       held_q, held_d;

  logic             out_free, accept;
  logic             shift, add_we;
  logic [IdxW-1:0]  slot;
  logic [IdxW:0]    slot_sum;
  logic [AddrW-1:0] add_len;
  logic             add_match;

  // ring head
  logic [AddrW-1:0] head_base, head_len;
  logic [AddrW-1:0] addr, addr_pg, q_end, r_end;
  logic             head_live, head_fits;
  logic             step_past, step_low, step_rsv;
  logic [IdxW-1:0]  pos_nxt;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // add decode
  always_comb begin
    if (!entry_format_i) begin
      add_match = (entry_type_i == TypeMultibootFree);
      add_len   = entry_size_i;
    end else begin
      add_match = (entry_type_i == TypeUefiFree);
      add_len   = {entry_size_i[AddrW-13:0], 12'h000};
    end
  end

  assign add_we = accept && (cmd_i == CmdAdd) && add_match &&
                  (total_q < CntW'(REGION_SLOTS));

  // physical cell of region index total: (total - pos) mod slots
  always_comb begin
    slot_sum = {1'b0, total_q[IdxW-1:0]} + (IdxW+1)'(REGION_SLOTS) - {1'b0, pos_q};
    if (slot_sum >= (IdxW+1)'(REGION_SLOTS)) slot_sum = slot_sum - (IdxW+1)'(REGION_SLOTS);
    slot = slot_sum[IdxW-1:0];
  end

  // head checks
  assign pos_nxt   = (pos_q == IdxW'(REGION_SLOTS - 1)) ? '0 : pos_q + 1'b1;
  assign head_live = CntW'(pos_q) < total_q;
  assign q_end     = qaddr_q + qlen_q;
  assign r_end     = head_base + head_len;
  assign head_fits = head_live && (qaddr_q >= head_base) && (q_end <= r_end);
  assign addr      = aligned_q + offset_q;
  assign addr_pg   = addr + PageBytes;
  assign step_past = addr >= end_q;
  assign step_low  = addr < LowMemLimit;
  assign step_rsv  = (addr < rsv_end_q) && (addr_pg > rsv_start_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && cmd_i == CmdQuery) state_d = S_QUERY;
        else if (accept && cmd_i == CmdAlloc) state_d = S_SEEK;
        else if (accept) state_d = S_DONE;
      end
      S_QUERY: if (qcnt_q == CntW'(REGION_SLOTS - 1)) state_d = S_DONE;
      S_SEEK: begin
        if (cursor_q >= total_q) state_d = S_DONE;
        else if (pos_q == cursor_q[IdxW-1:0]) state_d = S_ALIGN;
      end
      S_ALIGN: state_d = S_STEP;
      S_STEP: begin
        if (step_past) state_d = S_SEEK;
        else if (!step_low && !step_rsv) state_d = S_DONE;
      end
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    total_d      = total_q;
    cursor_d     = cursor_q;
    offset_d     = offset_q;
    pos_d        = pos_q;
    qcnt_d       = qcnt_q;
    qaddr_d      = qaddr_q;
    qlen_d       = qlen_q;
    aligned_d    = aligned_q;
    end_d        = end_q;
    res_status_d = res_status_q;
    res_frame_d  = res_frame_q;
    res_safe_d   = res_safe_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    frame_d      = frame_q;
    safe_d       = safe_q;
    held_d       = held_q;
    shift        = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          qaddr_d      = query_addr_i;
          qlen_d       = query_length_i;
          qcnt_d       = '0;
          res_status_d = StatusOk;
          res_frame_d  = '0;
          res_safe_d   = 1'b0;
          // add and unused command settle here and wait in done
          if (add_we) total_d = total_q + 1'b1;
          if (cmd_i == CmdAdd && add_match && !(total_q < CntW'(REGION_SLOTS)))
            res_status_d = StatusFull;
        end
      end
      S_QUERY: begin
        if (head_fits) res_safe_d = 1'b1;
        shift  = 1'b1;
        pos_d  = pos_nxt;
        qcnt_d = qcnt_q + 1'b1;
      end
      S_SEEK: begin
        if (cursor_q >= total_q) begin
          res_status_d = StatusOom;
          res_frame_d  = '0;
        end else if (pos_q != cursor_q[IdxW-1:0]) begin
          shift = 1'b1;
          pos_d = pos_nxt;
        end
      end
      S_ALIGN: begin
        aligned_d = (head_base + PageMask) & ~PageMask;
        end_d     = r_end;
      end
      S_STEP: begin
        if (step_past) begin
          cursor_d = cursor_q + 1'b1;
          offset_d = '0;
        end else if (step_low) begin
          offset_d = (LowMemLimit > aligned_q) ? LowMemLimit - aligned_q : '0;
        end else if (step_rsv) begin
          offset_d = (rsv_end_q > aligned_q) ? rsv_end_q - aligned_q
                                             : offset_q + PageBytes;
        end else begin
          offset_d     = offset_q + PageBytes;
          res_frame_d  = addr;
          res_status_d = StatusOk;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          frame_d     = res_frame_q;
          safe_d      = res_safe_q;
          held_d      = 7'(total_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      cursor_q    <= '0;
      offset_q    <= '0;
      pos_q       <= '0;
      qcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      cursor_q    <= cursor_d;
      offset_q    <= offset_d;
      pos_q       <= pos_d;
      qcnt_q      <= qcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qaddr_q      <= qaddr_d;
    qlen_q       <= qlen_d;
    aligned_q    <= aligned_d;
    end_q        <= end_d;
    res_status_q <= res_status_d;
    res_frame_q  <= res_frame_d;
    res_safe_q   <= res_safe_d;
    status_q     <= status_d;
    frame_q      <= frame_d;
    safe_q       <= safe_d;
    held_q       <= held_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign frame_addr_o   = frame_q;
  assign range_safe_o   = safe_q;
  assign regions_held_o = held_q;

  // region ring: cell i takes from cell i+1, the last from the head
  logic [AddrW-1:0] cell_base [REGION_SLOTS];
  logic [AddrW-1:0] cell_len  [REGION_SLOTS];

  for (genvar g = 0; g < REGION_SLOTS; g++) begin : g_ring
    localparam int unsigned Nxt = (g == REGION_SLOTS - 1) ? 0 : g + 1;
    rmfa_cell_ctl_t ctl;
    assign ctl.shift = shift;
    assign ctl.load  = add_we && (slot == IdxW'(g));
    rmfa_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .load_base_i (entry_base_i),
      .load_len_i  (add_len),
      .nbr_base_i  (cell_base[Nxt]),
      .nbr_len_i   (cell_len[Nxt]),
      .base_o      (cell_base[g]),
      .len_o       (cell_len[g])
    );
  end

  assign head_base = cell_base[0];
  assign head_len  = cell_len[0];

  // checks
  `RMFA_ASSERT(a_total_bound, total_q <= CntW'(REGION_SLOTS))
  `RMFA_ASSERT(a_cursor_bound, cursor_q <= total_q)
  `RMFA_ASSERT_NEXT(a_accept_idle, in_valid_i && !in_stall_o && cmd_i == CmdAlloc,
                    state_q == S_SEEK)
  `RMFA_ASSERT_NEXT(a_step_ring_still, state_q == S_ALIGN, $stable(pos_q))

endmodule

// ----- rtl/rmfa_cell.sv -----
module rmfa_cell
  import rmfa_pkg::*;
(
  input  logic             clk_i,
  input  rmfa_cell_ctl_t   ctl_i,
  input  logic [AddrW-1:0] load_base_i,
  input  logic [AddrW-1:0] load_len_i,
  input  logic [AddrW-1:0] nbr_base_i,
  input  logic [AddrW-1:0] nbr_len_i,
  output logic [AddrW-1:0] base_o,
  output logic [AddrW-1:0] len_o
);

  logic [AddrW-1:0] base_q, base_d;
  logic [AddrW-1:0] len_q, len_d;

  always_comb begin
    base_d = base_q;
    len_d  = len_q;
    if (ctl_i.load) begin
      base_d = load_base_i;
      len_d  = load_len_i;
    end else if (ctl_i.shift) begin
      base_d = nbr_base_i;
      len_d  = nbr_len_i;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    len_q  <= len_d;
  end

  assign base_o = base_q;
  assign len_o  = len_q;

endmodule

// ----- tb/sv/region_map_frame_allocator_checker.sv -----
module region_map_frame_allocator_checker
  import rmfa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [1:0]       cmd_i,
  input  logic             entry_format_i,
  input  logic [31:0]      entry_type_i,
  input  logic [AddrW-1:0] entry_base_i,
  input  logic [AddrW-1:0] entry_size_i,
  input  logic [AddrW-1:0] query_addr_i,
  input  logic [AddrW-1:0] query_length_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [1:0]       status_i,
  input  logic [AddrW-1:0] frame_addr_i,
  input  logic             range_safe_i,
  input  logic [6:0]       regions_held_i,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [AddrW-1:0] pwdata,
  input  logic             pready,
  output int               errors_o,
  output int               waiting_o,
  output int               frames_o,
  output int               oom_o,
  output int               dropped_o,
  output int               safe_hits_o
);

  localparam int Slots = 64;

  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] frame_addr;
    logic             range_safe;
    logic [6:0]       regions_held;
  } answer_t;

  logic [AddrW-1:0] free_base [Slots];
  logic [AddrW-1:0] free_len  [Slots];
  int unsigned      free_count;
  int unsigned      walk_region;
  logic [AddrW-1:0] walk_offset;
  logic [AddrW-1:0] keep_start, keep_end;
  answer_t          answers_due [$];

  function automatic answer_t allocate_frame();
    answer_t          a;
    int unsigned      guard;
    logic [AddrW-1:0] aligned, addr, lim;
    a = '0;
    a.status = StatusOom;
    guard = 4 * Slots + 16;
    while (walk_region < free_count) begin
      aligned = (free_base[walk_region] + PageMask) & ~PageMask;
      addr    = aligned + walk_offset;
      lim     = free_base[walk_region] + free_len[walk_region];
      if (guard == 0) break;
      guard--;
      if (addr >= lim) begin
        walk_region++;
        walk_offset = '0;
        continue;
      end
      if (addr < LowMemLimit) begin
        walk_offset = (LowMemLimit > aligned) ? LowMemLimit - aligned : '0;
        continue;
      end
      if (addr < keep_end && addr + PageBytes > keep_start) begin
        walk_offset = (keep_end > aligned) ? keep_end - aligned : walk_offset + PageBytes;
        continue;
      end
      walk_offset += PageBytes;
      a.status     = StatusOk;
      a.frame_addr = addr;
      break;
    end
    return a;
  endfunction

  function automatic answer_t predict_answer();
    answer_t          a;
    logic [AddrW-1:0] len;
    logic             free_type;
    a = '0;
    case (cmd_i)
      CmdAdd: begin
        free_type = entry_format_i ? (entry_type_i == TypeUefiFree)
                                   : (entry_type_i == TypeMultibootFree);
        len = entry_format_i ? entry_size_i * PageBytes : entry_size_i;
        if (free_type) begin
          if (free_count >= Slots) a.status = StatusFull;
          else begin
            free_base[free_count] = entry_base_i;
            free_len[free_count]  = len;
            free_count++;
          end
        end
      end
      CmdQuery: begin
        for (int i = 0; i < free_count; i++)
          if (query_addr_i >= free_base[i] &&
              query_addr_i + query_length_i <= free_base[i] + free_len[i]) begin
            a.range_safe = 1'b1;
            break;
          end
      end
      CmdAlloc: a = allocate_frame();
      default: ;
    endcase
    a.regions_held = 7'(free_count);
    return a;
  endfunction

  task automatic report_mismatch(input string what, input logic [AddrW-1:0] got,
                                 input logic [AddrW-1:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t a;
    if (!rst_ni) begin
      free_count  = 0;
      walk_region = 0;
      walk_offset = '0;
      keep_start  = '0;
      keep_end    = '0;
      answers_due.delete();
      errors_o = 0; waiting_o = 0; frames_o = 0; oom_o = 0; dropped_o = 0; safe_hits_o = 0;
    end else begin
      // register writes must land only while idle (the block does not enforce it), so order against beats is moot
      if (psel && penable && pwrite && pready) begin
        if (paddr == {RegReserveStart, 3'b000}) keep_start = pwdata;
        else if (paddr == {RegReserveEnd, 3'b000}) keep_end = pwdata;
      end
      if (in_valid_i && !in_stall_i) answers_due.push_back(predict_answer());
      if (out_valid_i && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          $display("result beat with nothing expected");
          errors_o++;
        end else begin
          a = answers_due.pop_front();
          if (status_i != a.status)
            report_mismatch("status", 64'(status_i), 64'(a.status));
          if (frame_addr_i != a.frame_addr)
            report_mismatch("frame_addr", frame_addr_i, a.frame_addr);
          if (range_safe_i != a.range_safe)
            report_mismatch("range_safe", 64'(range_safe_i), 64'(a.range_safe));
          if (regions_held_i != a.regions_held)
            report_mismatch("regions_held", 64'(regions_held_i), 64'(a.regions_held));
          if (a.status == StatusOom) oom_o++;
          if (a.status == StatusFull) dropped_o++;
          if (a.frame_addr != '0) frames_o++;
          if (a.range_safe) safe_hits_o++;
        end
      end
      waiting_o = answers_due.size();
    end
  end

endmodule

// ----- tb/sv/tb_region_map_frame_allocator_unit.sv -----
module tb_region_map_frame_allocator_unit;
  import rmfa_pkg::*;

  // the one command code the package leaves unnamed
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam logic [3:0] AddrReserveStart = {RegReserveStart, 3'b000};
  localparam logic [3:0] AddrReserveEnd   = {RegReserveEnd, 3'b000};
  localparam logic [AddrW-1:0] AllOnes = '1;

  logic             clk_i, rst_ni;
  logic             in_valid_i, in_stall_o;
  logic [1:0]       cmd_i;
  logic             entry_format_i;
  logic [31:0]      entry_type_i;
  logic [AddrW-1:0] entry_base_i, entry_size_i, query_addr_i, query_length_i;
  logic             out_valid_o, out_stall_i;
  logic [1:0]       status_o;
  logic [AddrW-1:0] frame_addr_o;
  logic             range_safe_o;
  logic [6:0]       regions_held_o;
  logic             psel, penable, pwrite, pready;
  logic [3:0]       paddr;
  logic [AddrW-1:0] pwdata, prdata;

  int errors, waiting, frames, oom, dropped, safe_hits;
  int beats_sent;
  bit gaps_on;  // random idling on both sides, cleared for the last part

  // free regions sent so far, used to aim queries inside real regions
  logic [AddrW-1:0] sent_base [64];
  logic [AddrW-1:0] sent_len  [64];
  int               sent_count;

  region_map_frame_allocator_unit dut (.*);

  region_map_frame_allocator_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .cmd_i, .entry_format_i, .entry_type_i,
    .entry_base_i, .entry_size_i, .query_addr_i, .query_length_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .frame_addr_i(frame_addr_o), .range_safe_i(range_safe_o),
    .regions_held_i(regions_held_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors_o(errors), .waiting_o(waiting), .frames_o(frames), .oom_o(oom),
    .dropped_o(dropped), .safe_hits_o(safe_hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #40000000;
    $display("Some tests failed");
    $finish;
  end

  // result side backpressure: random stall bursts
  always @(posedge clk_i or negedge rst_ni) begin
    int hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold = 0;
    end else if (hold > 0) begin
      hold--;
      if (hold == 0) out_stall_i <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      hold = $urandom_range(1, 7);
      out_stall_i <= 1'b1;
    end
  end

  // register write: setup cycle then access cycle
  task automatic reg_write(input logic [3:0] addr, input logic [AddrW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drain all answers, then give the block time to settle before a write
  task automatic set_reserve(input logic [AddrW-1:0] lo, input logic [AddrW-1:0] hi);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    reg_write(AddrReserveStart, lo);
    reg_write(AddrReserveEnd, hi);
  endtask

  // one command beat, with an optional idle burst ahead of it
  task automatic send_beat(input logic [1:0] cmd, input logic fmt, input logic [31:0] typ,
                           input logic [AddrW-1:0] base, input logic [AddrW-1:0] size,
                           input logic [AddrW-1:0] qaddr, input logic [AddrW-1:0] qlen);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    cmd_i          <= cmd;
    entry_format_i <= fmt;
    entry_type_i   <= typ;
    entry_base_i   <= base;
    entry_size_i   <= size;
    query_addr_i   <= qaddr;
    query_length_i <= qlen;
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
    if (cmd == CmdAdd && sent_count < 64 &&
        typ == (fmt ? TypeUefiFree : TypeMultibootFree)) begin
      sent_base[sent_count] = base;
      sent_len[sent_count]  = fmt ? size * PageBytes : size;
      sent_count++;
    end
  endtask

  function automatic logic [AddrW-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random command mix: mostly allocs, plus queries and small well-formed regions
  task automatic random_beat();
    int               pick, j;
    logic             fmt;
    logic [AddrW-1:0] base, size, qa, ql;
    pick = $urandom_range(0, 99);
    fmt  = 1'($urandom_range(0, 1));
    if (pick < 24) begin
      // free region, a few pages around the low megabytes
      base = 64'h80000 + 64'({$urandom_range(0, 4095), 12'h000}) +
             64'($urandom_range(0, 1) * $urandom_range(0, 4095));
      size = fmt ? 64'($urandom_range(0, 5)) : 64'($urandom_range(0, 5 * 4096));
      if ($urandom_range(0, 60) == 0) size = rand64();
      if ($urandom_range(0, 30) == 0) base = rand64();
      send_beat(CmdAdd, fmt, fmt ? TypeUefiFree : TypeMultibootFree, base, size,
                rand64(), rand64());
    end else if (pick < 30) begin
      // map entry of some other memory type
      send_beat(CmdAdd, fmt, $urandom(), rand64(), rand64(), rand64(), rand64());
    end else if (pick < 52) begin
      if (sent_count > 0 && $urandom_range(0, 3) != 0) begin
        j  = $urandom_range(0, sent_count - 1);
        qa = sent_base[j] + 64'($urandom_range(0, 8192)) -
             64'($urandom_range(0, 2) * 16);
        ql = $urandom_range(0, 3) == 0 ? 64'($urandom_range(0, 1)) : 64'($urandom_range(0, 24576));
      end else begin
        qa = rand64();
        ql = $urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 65536));
      end
      send_beat(CmdQuery, fmt, $urandom(), rand64(), rand64(), qa, ql);
    end else if (pick < 96) begin
      send_beat(CmdAlloc, fmt, $urandom(), rand64(), rand64(), rand64(), rand64());
    end else begin
      send_beat(CmdUnused, fmt, $urandom(), rand64(), rand64(), rand64(), rand64());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0; cmd_i = CmdAdd; entry_format_i = 1'b0; entry_type_i = '0;
    entry_base_i = '0; entry_size_i = '0; query_addr_i = '0; query_length_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    beats_sent = 0; sent_count = 0; gaps_on = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reserve a short unaligned window just above low memory
    set_reserve(64'h0010_2000, 64'h0010_3800);

    // directed: field extremes, ignored types, page wrap, unused command
    send_beat(CmdAlloc, 1'b0, '0, '0, '0, '0, '0);                       // empty table
    send_beat(CmdAdd, 1'b0, TypeMultibootFree, '0, 64'h0010_6000, '0, '0);  // spans low memory
    send_beat(CmdAdd, 1'b0, 32'd2, 64'h0020_0000, 64'h4000, '0, '0);       // wrong type
    send_beat(CmdAdd, 1'b1, TypeMultibootFree, 64'h0020_0000, 64'h4, '0, '0);
    send_beat(CmdAdd, 1'b0, TypeUefiFree, 64'h0020_0000, 64'h4000, '0, '0);
    send_beat(CmdAdd, 1'b1, '1, AllOnes, AllOnes, AllOnes, AllOnes);
    send_beat(CmdAdd, 1'b1, TypeUefiFree, 64'h0030_0123, 64'h0010_0000_0000_0003, '0, '0);
    send_beat(CmdUnused, 1'b1, '1, AllOnes, AllOnes, AllOnes, AllOnes);
    send_beat(CmdQuery, 1'b0, '0, '0, '0, '0, '0);
    send_beat(CmdQuery, 1'b0, '0, '0, '0, 64'h0010_0000, 64'h6000);
    send_beat(CmdQuery, 1'b0, '0, '0, '0, 64'h0010_0000, 64'h6001);
    send_beat(CmdQuery, 1'b0, '0, '0, '0, AllOnes, AllOnes);
    repeat (8) send_beat(CmdAlloc, 1'b0, '0, '0, '0, '0, '0);
    send_beat(CmdAdd, 1'b0, TypeMultibootFree, AllOnes, AllOnes, '0, '0); // end wraps
    send_beat(CmdAlloc, 1'b1, '1, AllOnes, AllOnes, AllOnes, AllOnes);

    // random phases across reserve settings, extremes included
    repeat (330) random_beat();
    set_reserve('0, AllOnes);
    repeat (330) random_beat();
    set_reserve(AllOnes, '0);
    repeat (330) random_beat();
    set_reserve(rand64() & 64'h0000_0000_00FF_FFFF, rand64() & 64'h0000_0000_01FF_FFFF);
    gaps_on = 1'b0;
    repeat (340) random_beat();
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (waiting != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("sent %0d command beats over four reserve windows", beats_sent);
    $display("frames %0d, out of memory %0d, dropped adds %0d, safe ranges %0d",
             frames, oom, dropped, safe_hits);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rmfa_pkg.sv
rtl/rmfa_cell.sv
rtl/region_map_frame_allocator_unit.sv
tb/sv/region_map_frame_allocator_checker.sv
tb/sv/tb_region_map_frame_allocator_unit.sv
